/* hdl/assert_macros.svh */
// Assertion helpers used by the RTL sequencer (abkf_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ABKF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ABKF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/abkf_pkg.sv */
package abkf_pkg;

    typedef logic signed [71:0] wide_t;

    localparam logic [23:0] Q_ANGLE_RST    = 24'd16777;
    localparam logic [23:0] Q_BIAS_RST     = 24'd50332;
    localparam logic [23:0] MEAS_NOISE_RST = 24'd503316;

    localparam wide_t MAX32_W = 72'sd2147483647;
    localparam wide_t MIN32_W = -72'sd2147483648;

    // Divider: 62 quotient bits, two per cycle.
    localparam int DIV_STEPS = 31;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        REG_Q_ANGLE    = 2'd0,
        REG_Q_BIAS     = 2'd1,
        REG_MEAS_NOISE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [23:0] q_angle;
        logic [23:0] q_bias;
        logic [23:0] meas_noise;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RATE,
        OP_P11,
        OP_QB,
        OP_INNER,
        OP_P00,
        OP_DIV0,
        OP_K0,
        OP_DIV1,
        OP_K1,
        OP_K0Y,
        OP_K1Y,
        OP_K0P00,
        OP_K0P01,
        OP_K1P00,
        OP_K1P01,
        OP_FINISH,
        OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RATE,
        ST_P11,
        ST_QB,
        ST_INNER,
        ST_P00,
        ST_DIV0,
        ST_WAIT0,
        ST_DIV1,
        ST_WAIT1,
        ST_K0Y,
        ST_K1Y,
        ST_K0P00,
        ST_K0P01,
        ST_K1P00,
        ST_K1P01,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic out_full;
    } sts_t;

    function automatic logic signed [31:0] sat32(input wide_t x);
        if (x > MAX32_W)
            return 32'sh7fffffff;
        else if (x < MIN32_W)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    // Round to nearest, ties up: floor((x + 2^(k-1)) / 2^k).
    function automatic wide_t rnd(input wide_t x, input int unsigned k);
        wide_t half;
        half = 72'sd1 <<< (k - 1);
        return (x + half) >>> k;
    endfunction

endpackage

/* hdl/angle_bias_kalman_filter.sv */
// Angle and gyro-bias Kalman filter, one update per input beat.
// Each update runs prediction (rate, P11, QB, inner, P00), then two gain divisions
// on one shared radix-4 divider (start, 31 steps, finish, capture), then correction
// (K0Y, K1Y, K0P00, K0P01, K1P00, K1P01, finish) and the output beat.
// A new beat is taken only after the last one's output beat is issued, which waits while the output is full.
// Reset (rst_n low, async): estimates and covariance clear, noise registers load defaults.
module angle_bias_kalman_filter (
    input  logic                clk,
    input  logic                rst_n,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic        [3:0]   paddr,
    input  logic        [31:0]  pwdata,
    output logic        [31:0]  prdata,
    output logic                pready,
    // Input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  measured_angle,
    input  logic signed [31:0]  measured_rate,
    input  logic        [19:0]  elapsed_time,
    // Output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  angle_estimate,
    output logic signed [31:0]  bias_estimate
);

    abkf_pkg::cfg_t   cfg_reg;
    abkf_pkg::cmd_t   cmd;
    abkf_pkg::sts_t   sts;
    abkf_pkg::reg_idx_t reg_idx;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = abkf_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    // Noise registers; writes to the unused slot are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.q_angle    <= abkf_pkg::Q_ANGLE_RST;
            cfg_reg.q_bias     <= abkf_pkg::Q_BIAS_RST;
            cfg_reg.meas_noise <= abkf_pkg::MEAS_NOISE_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                abkf_pkg::REG_Q_ANGLE:    cfg_reg.q_angle    <= pwdata[23:0];
                abkf_pkg::REG_Q_BIAS:     cfg_reg.q_bias     <= pwdata[23:0];
                abkf_pkg::REG_MEAS_NOISE: cfg_reg.meas_noise <= pwdata[23:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            abkf_pkg::REG_Q_ANGLE:    prdata = {8'd0, cfg_reg.q_angle};
            abkf_pkg::REG_Q_BIAS:     prdata = {8'd0, cfg_reg.q_bias};
            abkf_pkg::REG_MEAS_NOISE: prdata = {8'd0, cfg_reg.meas_noise};
            default:                  prdata = '0;
        endcase
    end

    // Sequencer: steps one update through the shared multiplier and divider.
    abkf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // Datapath: filter state, working registers, multiplier, divider, output beat.
    abkf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg_reg),
        .measured_angle (measured_angle),
        .measured_rate  (measured_rate),
        .elapsed_time   (elapsed_time),
        .out_stall      (out_stall),
        .sts            (sts),
        .out_valid      (out_valid),
        .angle_estimate (angle_estimate),
        .bias_estimate  (bias_estimate)
    );

endmodule

/* hdl/abkf_div.sv */
module abkf_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  num,
    input  logic signed [32:0]  den,
    output logic                busy,
    output logic                done,
    output logic signed [31:0]  gain
);

    logic [61:0] dvd_reg, dvd_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] d_reg;
    logic        neg_reg;
    logic        zero_reg;
    logic        busy_reg;
    logic        fin_reg;
    logic        done_reg;
    logic [abkf_pkg::DIV_CW-1:0] cnt_reg;
    logic signed [31:0] gain_reg;

    logic [33:0] r1, r2;
    logic        b1, b2;
    logic [31:0] num_mag;
    logic [32:0] den_mag;

    assign num_mag = num[31] ? 32'(-num) : 32'(num);
    assign den_mag = den[32] ? 33'(-den) : 33'(den);

    // Two restoring steps per cycle.
    always_comb
    begin
        r1 = {rem_reg[32:0], dvd_reg[61]};
        b1 = (r1 >= {1'b0, d_reg});
        if (b1)
            r1 = r1 - {1'b0, d_reg};
        r2 = {r1[32:0], dvd_reg[60]};
        b2 = (r2 >= {1'b0, d_reg});
        if (b2)
            r2 = r2 - {1'b0, d_reg};
        rem_next = r2;
        dvd_next = {dvd_reg[59:0], b1, b2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == abkf_pkg::DIV_CW'(abkf_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= {num_mag, 30'd0};
            rem_reg  <= '0;
            d_reg    <= den_mag;
            neg_reg  <= num[31] ^ den[32];
            zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        if (fin_reg)
        begin
            if (zero_reg)
                gain_reg <= '0;
            else if (!neg_reg)
                gain_reg <= (dvd_reg > 62'd2147483647) ? 32'sh7fffffff
                                                       : $signed(dvd_reg[31:0]);
            else
                gain_reg <= (dvd_reg > 62'd2147483648) ? 32'sh80000000
                                                       : $signed(32'(-dvd_reg[31:0]));
        end
    end

    assign busy = busy_reg | fin_reg;
    assign done = done_reg;
    assign gain = gain_reg;

endmodule

/* hdl/abkf_dp.sv */
module abkf_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  abkf_pkg::cmd_t       cmd,
    input  abkf_pkg::cfg_t       cfg,
    input  logic signed [31:0]   measured_angle,
    input  logic signed [31:0]   measured_rate,
    input  logic        [19:0]   elapsed_time,
    input  logic                 out_stall,
    output abkf_pkg::sts_t       sts,
    output logic                 out_valid,
    output logic signed [31:0]   angle_estimate,
    output logic signed [31:0]   bias_estimate
);

    // Filter state
    logic signed [31:0] angle_state_reg;
    logic signed [31:0] bias_state_reg;
    logic signed [31:0] cov_reg [4];

    // Working registers for one update
    logic        [19:0] dt_reg;
    logic signed [31:0] meas_reg;
    logic signed [31:0] rate_reg;
    logic signed [31:0] ang_reg;
    logic signed [37:0] dtp11_reg;
    logic signed [37:0] inner_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] y_reg;
    logic signed [31:0] k0_reg, k1_reg;
    abkf_pkg::wide_t    prod_reg;

    logic               out_valid_reg;
    logic signed [31:0] angle_out_reg, bias_out_reg;

    logic signed [38:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [38:0] dt_a;
    logic signed [32:0] dt_b;
    abkf_pkg::wide_t    dtp11_w, qa_w, rm_w, den_w, rnd16, rnd24, rnd30;

    logic               div_start, div_busy, div_done;
    logic signed [31:0] div_num, div_gain;

    assign dt_a  = $signed({19'd0, dt_reg});
    assign dt_b  = $signed({13'd0, dt_reg});
    assign qa_w  = abkf_pkg::rnd({48'd0, cfg.q_angle}, 8);
    assign rm_w  = abkf_pkg::rnd({48'd0, cfg.meas_noise}, 8);
    assign rnd16 = abkf_pkg::rnd(prod_reg, 16);
    assign rnd24 = abkf_pkg::rnd(prod_reg, 24);
    assign rnd30 = abkf_pkg::rnd(prod_reg, 30);
    assign dtp11_w = rnd16;
    assign den_w = abkf_pkg::wide_t'(p00_reg) + rm_w;

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            abkf_pkg::OP_RATE:  begin mul_a = dt_a; mul_b = 33'(rate_reg); end
            abkf_pkg::OP_P11:   begin mul_a = dt_a; mul_b = 33'(cov_reg[3]); end
            abkf_pkg::OP_QB:    begin mul_a = $signed({15'd0, cfg.q_bias}); mul_b = dt_b; end
            abkf_pkg::OP_INNER: begin mul_a = 39'(inner_reg); mul_b = dt_b; end
            abkf_pkg::OP_K0Y:   begin mul_a = 39'(k0_reg); mul_b = 33'(y_reg); end
            abkf_pkg::OP_K1Y:   begin mul_a = 39'(k1_reg); mul_b = 33'(y_reg); end
            abkf_pkg::OP_K0P00: begin mul_a = 39'(k0_reg); mul_b = 33'(p00_reg); end
            abkf_pkg::OP_K0P01: begin mul_a = 39'(k0_reg); mul_b = 33'(p01_reg); end
            abkf_pkg::OP_K1P00: begin mul_a = 39'(k1_reg); mul_b = 33'(p00_reg); end
            abkf_pkg::OP_K1P01: begin mul_a = 39'(k1_reg); mul_b = 33'(p01_reg); end
            default:            begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign div_start = (cmd.op == abkf_pkg::OP_DIV0) || (cmd.op == abkf_pkg::OP_DIV1);
    assign div_num   = (cmd.op == abkf_pkg::OP_DIV1) ? p10_reg : p00_reg;

    abkf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_w[32:0]),
        .busy  (div_busy),
        .done  (div_done),
        .gain  (div_gain)
    );

    // Working registers: each op that uses a product consumes the product of the op before it.
    always_ff @(posedge clk)
    begin
        prod_reg <= abkf_pkg::wide_t'(mul_a) * abkf_pkg::wide_t'(mul_b);
        case (cmd.op)
            abkf_pkg::OP_LOAD:
            begin
                dt_reg   <= elapsed_time;
                meas_reg <= measured_angle;
                rate_reg <= abkf_pkg::sat32(abkf_pkg::wide_t'(measured_rate)
                                            - abkf_pkg::wide_t'(bias_state_reg));
            end
            abkf_pkg::OP_P11:
                ang_reg <= abkf_pkg::sat32(abkf_pkg::wide_t'(angle_state_reg) + rnd16);
            abkf_pkg::OP_QB:
            begin
                dtp11_reg <= dtp11_w[37:0];
                inner_reg <= 38'(dtp11_w - abkf_pkg::wide_t'(cov_reg[1])
                                 - abkf_pkg::wide_t'(cov_reg[2]) + qa_w);
            end
            abkf_pkg::OP_INNER:
            begin
                p11_reg <= abkf_pkg::sat32(abkf_pkg::wide_t'(cov_reg[3]) + rnd24);
                p01_reg <= abkf_pkg::sat32(abkf_pkg::wide_t'(cov_reg[1])
                                           - abkf_pkg::wide_t'(dtp11_reg));
                p10_reg <= abkf_pkg::sat32(abkf_pkg::wide_t'(cov_reg[2])
                                           - abkf_pkg::wide_t'(dtp11_reg));
            end
            abkf_pkg::OP_P00:
                p00_reg <= abkf_pkg::sat32(abkf_pkg::wide_t'(cov_reg[0]) + rnd16);
            abkf_pkg::OP_DIV0:
                y_reg <= abkf_pkg::sat32(abkf_pkg::wide_t'(meas_reg)
                                         - abkf_pkg::wide_t'(ang_reg));
            abkf_pkg::OP_K0:
                k0_reg <= div_gain;
            abkf_pkg::OP_K1:
                k1_reg <= div_gain;
            abkf_pkg::OP_K1Y:
                ang_reg <= abkf_pkg::sat32(abkf_pkg::wide_t'(ang_reg) + rnd30);
            default:
            begin
            end
        endcase
    end

    // Filter state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_state_reg <= '0;
            bias_state_reg  <= '0;
            cov_reg[0]      <= '0;
            cov_reg[1]      <= '0;
            cov_reg[2]      <= '0;
            cov_reg[3]      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                abkf_pkg::OP_K0P00:
                    bias_state_reg <= abkf_pkg::sat32(abkf_pkg::wide_t'(bias_state_reg)
                                                      + rnd30);
                abkf_pkg::OP_K0P01:
                    cov_reg[0] <= abkf_pkg::sat32(abkf_pkg::wide_t'(p00_reg) - rnd30);
                abkf_pkg::OP_K1P00:
                    cov_reg[1] <= abkf_pkg::sat32(abkf_pkg::wide_t'(p01_reg) - rnd30);
                abkf_pkg::OP_K1P01:
                    cov_reg[2] <= abkf_pkg::sat32(abkf_pkg::wide_t'(p10_reg) - rnd30);
                abkf_pkg::OP_FINISH:
                begin
                    cov_reg[3]      <= abkf_pkg::sat32(abkf_pkg::wide_t'(p11_reg) - rnd30);
                    angle_state_reg <= ang_reg;
                end
                abkf_pkg::OP_OUT:
                    out_valid_reg <= 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == abkf_pkg::OP_OUT)
        begin
            angle_out_reg <= angle_state_reg;
            bias_out_reg  <= bias_state_reg;
        end
    end

    assign sts.div_busy = div_busy;
    assign sts.div_done = div_done;
    assign sts.out_full = out_valid_reg & out_stall;

    assign out_valid      = out_valid_reg;
    assign angle_estimate = angle_out_reg;
    assign bias_estimate  = bias_out_reg;

endmodule

/* hdl/abkf_ctrl.sv */
`include "assert_macros.svh"

module abkf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  abkf_pkg::sts_t  sts,
    output logic            in_stall,
    output abkf_pkg::cmd_t  cmd
);

    abkf_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= abkf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = abkf_pkg::OP_NONE;
        case (state_reg)
            abkf_pkg::ST_IDLE:
                if (in_valid)
                begin
                    cmd.op     = abkf_pkg::OP_LOAD;
                    state_next = abkf_pkg::ST_RATE;
                end
            abkf_pkg::ST_RATE:
            begin
                cmd.op     = abkf_pkg::OP_RATE;
                state_next = abkf_pkg::ST_P11;
            end
            abkf_pkg::ST_P11:
            begin
                cmd.op     = abkf_pkg::OP_P11;
                state_next = abkf_pkg::ST_QB;
            end
            abkf_pkg::ST_QB:
            begin
                cmd.op     = abkf_pkg::OP_QB;
                state_next = abkf_pkg::ST_INNER;
            end
            abkf_pkg::ST_INNER:
            begin
                cmd.op     = abkf_pkg::OP_INNER;
                state_next = abkf_pkg::ST_P00;
            end
            abkf_pkg::ST_P00:
            begin
                cmd.op     = abkf_pkg::OP_P00;
                state_next = abkf_pkg::ST_DIV0;
            end
            abkf_pkg::ST_DIV0:
            begin
                cmd.op     = abkf_pkg::OP_DIV0;
                state_next = abkf_pkg::ST_WAIT0;
            end
            abkf_pkg::ST_WAIT0:
                if (sts.div_done)
                begin
                    cmd.op     = abkf_pkg::OP_K0;
                    state_next = abkf_pkg::ST_DIV1;
                end
            abkf_pkg::ST_DIV1:
            begin
                cmd.op     = abkf_pkg::OP_DIV1;
                state_next = abkf_pkg::ST_WAIT1;
            end
            abkf_pkg::ST_WAIT1:
                if (sts.div_done)
                begin
                    cmd.op     = abkf_pkg::OP_K1;
                    state_next = abkf_pkg::ST_K0Y;
                end
            abkf_pkg::ST_K0Y:
            begin
                cmd.op     = abkf_pkg::OP_K0Y;
                state_next = abkf_pkg::ST_K1Y;
            end
            abkf_pkg::ST_K1Y:
            begin
                cmd.op     = abkf_pkg::OP_K1Y;
                state_next = abkf_pkg::ST_K0P00;
            end
            abkf_pkg::ST_K0P00:
            begin
                cmd.op     = abkf_pkg::OP_K0P00;
                state_next = abkf_pkg::ST_K0P01;
            end
            abkf_pkg::ST_K0P01:
            begin
                cmd.op     = abkf_pkg::OP_K0P01;
                state_next = abkf_pkg::ST_K1P00;
            end
            abkf_pkg::ST_K1P00:
            begin
                cmd.op     = abkf_pkg::OP_K1P00;
                state_next = abkf_pkg::ST_K1P01;
            end
            abkf_pkg::ST_K1P01:
            begin
                cmd.op     = abkf_pkg::OP_K1P01;
                state_next = abkf_pkg::ST_FINISH;
            end
            abkf_pkg::ST_FINISH:
            begin
                cmd.op     = abkf_pkg::OP_FINISH;
                state_next = abkf_pkg::ST_OUT;
            end
            abkf_pkg::ST_OUT:
                if (!sts.out_full)
                begin
                    cmd.op     = abkf_pkg::OP_OUT;
                    state_next = abkf_pkg::ST_IDLE;
                end
            default:
                state_next = abkf_pkg::ST_IDLE;
        endcase
    end

    assign in_stall = (state_reg != abkf_pkg::ST_IDLE);

    `ABKF_ASSERT_IMP(a_div_start_free, clk, rst_n, cmd.op == abkf_pkg::OP_DIV0 || cmd.op == abkf_pkg::OP_DIV1, !sts.div_busy, "divider started while busy")
    `ABKF_ASSERT_IMP(a_div_done_wait, clk, rst_n, sts.div_done, state_reg == abkf_pkg::ST_WAIT0 || state_reg == abkf_pkg::ST_WAIT1, "divider result outside a wait state")
    `ABKF_ASSERT_NEXT(a_div_runs, clk, rst_n, cmd.op == abkf_pkg::OP_DIV0 || cmd.op == abkf_pkg::OP_DIV1, sts.div_busy, "divider did not start")

endmodule

/* sim/abkf_checker.sv */
`timescale 1ns / 100ps

module abkf_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic        [3:0]   paddr,
    input  logic        [31:0]  pwdata,
    input  logic                pready,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic signed [31:0]  measured_angle,
    input  logic signed [31:0]  measured_rate,
    input  logic        [19:0]  elapsed_time,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic signed [31:0]  angle_estimate,
    input  logic signed [31:0]  bias_estimate,
    output int                  fail_count,
    output int                  pending_count,
    output logic                beat_seen
);

    typedef logic signed [127:0] acc_t;

    typedef struct packed {
        logic signed [31:0] angle;
        logic signed [31:0] bias;
    } estimate_t;

    logic [23:0]        noise_angle, noise_bias, noise_meas;
    logic signed [31:0] angle_est, bias_est;
    logic signed [31:0] cov [4];
    estimate_t          estimate_q [$];

    function automatic acc_t clip32(input acc_t x);
        if (x > acc_t'(32'sh7fffffff))
            return acc_t'(32'sh7fffffff);
        if (x < -acc_t'(64'sd2147483648))
            return -acc_t'(64'sd2147483648);
        return x;
    endfunction

    // nearest, ties upward: arithmetic shift of x + half is floor
    function automatic acc_t round_shift(input acc_t x, input int k);
        return (x + (acc_t'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic acc_t kalman_gain(input acc_t num, input acc_t s);
        if (s == 0)
            return 0;
        return clip32((num <<< 30) / s);  // SV divide truncates toward zero
    endfunction

    task automatic predict_update(input logic signed [31:0] meas_in,
                                  input logic signed [31:0] rate_in,
                                  input logic [19:0] dt_in);
        acc_t meas, dt, p00, p01, p10, p11, qa, rm;
        acc_t rate, ang, dtp11, inner, s, k0, k1, y, bias;
        estimate_t e;
        meas = meas_in;
        dt = {108'd0, dt_in};
        p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
        qa = round_shift({104'd0, noise_angle}, 8);
        rm = round_shift({104'd0, noise_meas}, 8);
        rate = clip32(acc_t'(rate_in) - acc_t'(bias_est));
        ang = clip32(acc_t'(angle_est) + round_shift(dt * rate, 16));
        dtp11 = round_shift(dt * p11, 16);
        inner = dtp11 - p01 - p10 + qa;
        p00 = clip32(p00 + round_shift(dt * inner, 16));
        p01 = clip32(p01 - dtp11);
        p10 = clip32(p10 - dtp11);
        p11 = clip32(p11 + round_shift({104'd0, noise_bias} * dt, 24));
        s = p00 + rm;
        k0 = kalman_gain(p00, s);
        k1 = kalman_gain(p10, s);
        y = clip32(meas - ang);
        ang = clip32(ang + round_shift(k0 * y, 30));
        bias = clip32(acc_t'(bias_est) + round_shift(k1 * y, 30));
        cov[0] = 32'(clip32(p00 - round_shift(k0 * p00, 30)));
        cov[1] = 32'(clip32(p01 - round_shift(k0 * p01, 30)));
        cov[2] = 32'(clip32(p10 - round_shift(k1 * p00, 30)));
        cov[3] = 32'(clip32(p11 - round_shift(k1 * p01, 30)));
        angle_est = 32'(ang);
        bias_est = 32'(bias);
        e.angle = angle_est;
        e.bias = bias_est;
        estimate_q.push_back(e);
    endtask

    assign pending_count = estimate_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        estimate_t e;
        if (!rst_n)
        begin
            noise_angle <= abkf_pkg::Q_ANGLE_RST;
            noise_bias <= abkf_pkg::Q_BIAS_RST;
            noise_meas <= abkf_pkg::MEAS_NOISE_RST;
            angle_est = 0;
            bias_est = 0;
            for (int i = 0; i < 4; i++)
                cov[i] = 0;
            fail_count <= 0;
            beat_seen <= 1'b0;
        end
        else
        begin
            beat_seen <= (in_valid && !in_stall) || (out_valid && !out_stall);
            if (psel && penable && pwrite && pready)
            begin
                case (abkf_pkg::reg_idx_t'(paddr[3:2]))
                    abkf_pkg::REG_Q_ANGLE:    noise_angle <= pwdata[23:0];
                    abkf_pkg::REG_Q_BIAS:     noise_bias <= pwdata[23:0];
                    abkf_pkg::REG_MEAS_NOISE: noise_meas <= pwdata[23:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_update(measured_angle, measured_rate, elapsed_time);
            if (out_valid && !out_stall)
            begin
                if (estimate_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected estimate beat: angle %0d bias %0d",
                                 angle_estimate, bias_estimate);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = estimate_q.pop_front();
                    if (e.angle !== angle_estimate || e.bias !== bias_estimate)
                    begin
                        if (fail_count < 10)
                            $display("estimate mismatch: exp angle %0d bias %0d, got %0d %0d",
                                     e.angle, e.bias, angle_estimate, bias_estimate);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* sim/tb_angle_bias_kalman_filter.sv */
`timescale 1ns / 100ps

module tb_angle_bias_kalman_filter;

    localparam int WATCHDOG_LIMIT = 4000;  // one full update plus long stalls
    localparam int DRAIN_CYCLES   = 120;

    logic               clk, rst_n;
    logic               psel, penable, pwrite, pready;
    logic        [3:0]  paddr;
    logic        [31:0] pwdata, prdata;
    logic               in_valid, in_stall, out_valid, out_stall;
    logic signed [31:0] measured_angle, measured_rate;
    logic        [19:0] elapsed_time;
    logic signed [31:0] angle_estimate, bias_estimate;
    int                 fail_count, pending_count;
    logic               beat_seen;

    // stall/idle rates in percent, changed per phase
    int  send_idle_pct, recv_stall_pct;
    bit  hold_off;   // long receiver hold-off for back-pressure
    int  idle_cycles;

    angle_bias_kalman_filter i_dut (.*);

    abkf_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stall, or solid stall while holding off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles with no beat accepted
    always @(posedge clk)
    begin
        if (!rst_n || beat_seen || pending_count == 0 && !in_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic reg_write(input abkf_pkg::reg_idx_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // one input beat; valid stays high across back-to-back beats
    task automatic send_beat(input logic signed [31:0] meas,
                             input logic signed [31:0] rate,
                             input logic [19:0] dt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        measured_angle <= meas;
        measured_rate <= rate;
        elapsed_time <= dt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic random_beat();
        logic signed [31:0] meas, rate;
        logic [19:0] dt;
        case ($urandom_range(9))
            0: meas = $urandom();
            1: meas = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: meas = $signed($urandom_range(0, 2 * 5898240)) - 32'sd5898240;
        endcase
        case ($urandom_range(9))
            0: rate = $urandom();
            default: rate = $signed($urandom_range(0, 2 * 16384000)) - 32'sd16384000;
        endcase
        case ($urandom_range(9))
            0: dt = 20'($urandom());
            1: dt = 20'd0;
            default: dt = 20'($urandom_range(1, 1311));  // about 15 us to 20 ms
        endcase
        send_beat(meas, rate, dt);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int beats);
        for (int n = 0; n < beats; n++)
            random_beat();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        measured_angle = '0;
        measured_rate = '0;
        elapsed_time = '0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset defaults, field extremes, zero dt, saturation
        send_beat(32'sd0, 32'sd0, 20'd0);
        send_beat(32'sh7fffffff, 32'sh7fffffff, 20'hfffff);
        send_beat(32'sh80000000, 32'sh80000000, 20'hfffff);
        send_beat(32'sh80000000, 32'sh7fffffff, 20'd0);
        send_beat(32'sh7fffffff, 32'sh80000000, 20'd1);
        send_beat(32'sd655360, 32'sd65536, 20'd655);
        send_beat(-32'sd655360, -32'sd65536, 20'd65536);
        drain();

        // zero noise everywhere: S can be zero, gains zero
        reg_write(abkf_pkg::REG_Q_ANGLE, 32'd0);
        reg_write(abkf_pkg::REG_Q_BIAS, 32'd0);
        reg_write(abkf_pkg::REG_MEAS_NOISE, 32'd0);
        send_beat(32'sd100, 32'sd0, 20'd0);
        send_beat(32'sd65536, 32'sd0, 20'd0);
        send_beat(-32'sd65536, 32'sd3000, 20'd1000);
        drain();

        // max noise: large covariance growth, bits 31:24 of pwdata ignored
        reg_write(abkf_pkg::REG_Q_ANGLE, 32'hffffffff);
        reg_write(abkf_pkg::REG_Q_BIAS, 32'hffffffff);
        reg_write(abkf_pkg::REG_MEAS_NOISE, 32'h00ffffff);
        for (int n = 0; n < 8; n++)
            send_beat(32'sh7fffffff, 32'sh80000000, 20'hfffff);
        drain();
        reg_write(abkf_pkg::REG_MEAS_NOISE, 32'd0);  // tiny R with big P: gain saturation
        send_beat(32'sh80000000, 32'sh7fffffff, 20'hfffff);
        send_beat(32'sd0, 32'sd0, 20'd12);
        drain();

        // sender idles 14%, receiver 55%, random noise settings
        reg_write(abkf_pkg::REG_Q_ANGLE, $urandom());
        reg_write(abkf_pkg::REG_Q_BIAS, $urandom());
        reg_write(abkf_pkg::REG_MEAS_NOISE, $urandom());
        send_idle_pct = 14;
        recv_stall_pct = 55;
        random_phase(550);
        drain();

        // back to defaults; sender idles 55%, receiver 14%
        reg_write(abkf_pkg::REG_Q_ANGLE, {8'd0, abkf_pkg::Q_ANGLE_RST});
        reg_write(abkf_pkg::REG_Q_BIAS, {8'd0, abkf_pkg::Q_BIAS_RST});
        reg_write(abkf_pkg::REG_MEAS_NOISE, {8'd0, abkf_pkg::MEAS_NOISE_RST});
        send_idle_pct = 55;
        recv_stall_pct = 14;
        random_phase(550);
        drain();

        // no idling, with one long receiver hold-off while input keeps coming
        reg_write(abkf_pkg::REG_Q_ANGLE, 32'd1);
        reg_write(abkf_pkg::REG_MEAS_NOISE, 32'd1 << $urandom_range(23));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(630);
        join
        drain();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
